@@ rtl/core/pcfc_pkg.sv @@
// ----------------------------------------------------------------------------
// pcfc_pkg
// Types, constants and helper functions for the pixel format converter.
// ----------------------------------------------------------------------------
package pcfc_pkg;

	localparam logic [31:0] DESCRIPTOR_RESET = 32'h0008_1828;
	localparam logic [18:0] GREY_WEIGHT_R    = 19'd156763;
	localparam logic [18:0] GREY_WEIGHT_G    = 19'd307758;
	localparam logic [18:0] GREY_WEIGHT_B    = 19'd59769;
	localparam logic [7:0]  COLOR_DEFAULT    = 8'hAA;
	localparam logic [7:0]  ALPHA_DEFAULT    = 8'hFF;

	typedef enum logic {
		OP_UNPACK = 1'b0,
		OP_PACK   = 1'b1
	} opcode_t;

	typedef enum logic [3:0] {
		CH_RED   = 4'd0,
		CH_GREEN = 4'd1,
		CH_BLUE  = 4'd2,
		CH_GREY  = 4'd3,
		CH_ALPHA = 4'd4
	} chan_kind_t;

	typedef struct packed {
		logic [3:0] kind;
		logic [3:0] nbits;
		logic [5:0] pos;
	} chan_t;

	typedef chan_t [3:0] desc_t;

	function automatic desc_t decode_desc(input logic [31:0] raw);
		desc_t      d;
		logic [5:0] pos;
		pos = 6'd0;
		for (int i = 0; i < 4; i++) begin
			d[i].kind  = raw[8*i+4 +: 4];
			d[i].nbits = raw[8*i +: 4];
			d[i].pos   = pos;
			pos        = pos + {2'b00, raw[8*i +: 4]};
		end
		return d;
	endfunction

	function automatic logic [7:0] widen_to_8(input logic [14:0] f, input logic [3:0] nb);
		logic [7:0]  v;
		logic [14:0] sh;
		sh = f >> (nb - 4'd8);
		unique case (nb)
			4'd1:    v = {8{f[0]}};
			4'd2:    v = {4{f[1:0]}};
			4'd3:    v = {f[2:0], f[2:0], f[2:1]};
			4'd4:    v = {2{f[3:0]}};
			4'd5:    v = {f[4:0], f[4:2]};
			4'd6:    v = {f[5:0], f[5:4]};
			4'd7:    v = {f[6:0], f[6]};
			default: v = sh[7:0];
		endcase
		return v;
	endfunction

	function automatic logic [14:0] narrow_from_8(input logic [7:0] c, input logic [3:0] nb);
		logic [14:0] f;
		if (nb <= 4'd8) begin
			f = {7'd0, c >> (4'd8 - nb)};
		end else begin
			f = {7'd0, c} << (nb - 4'd8);
		end
		return f;
	endfunction

endpackage

@@ rtl/core/pcfc_convert.sv @@
// ----------------------------------------------------------------------------
// pcfc_convert
// Combinational unpack of a packed pixel to RGBA, or pack of RGBA to a pixel.
// ----------------------------------------------------------------------------
module pcfc_convert import pcfc_pkg::*; (
	input  logic        op,
	input  logic [31:0] value,
	input  desc_t       desc,
	output logic [31:0] result
);

	logic [7:0]  r_in, g_in, b_in, a_in;
	logic [26:0] grey_sum;
	logic [7:0]  grey;
	logic [31:0] unpacked;
	logic [31:0] packed_px;

	assign r_in = value[31:24];
	assign g_in = value[23:16];
	assign b_in = value[15:8];
	assign a_in = value[7:0];

	assign grey_sum = 27'(GREY_WEIGHT_R) * 27'(r_in)
	                + 27'(GREY_WEIGHT_G) * 27'(g_in)
	                + 27'(GREY_WEIGHT_B) * 27'(b_in);
	assign grey = grey_sum[26:19];

	always_comb begin
		logic [7:0]  r, g, b, a, v;
		logic [63:0] sh;
		logic [15:0] mask;
		logic [14:0] fld;
		r = COLOR_DEFAULT;
		g = COLOR_DEFAULT;
		b = COLOR_DEFAULT;
		a = ALPHA_DEFAULT;
		for (int i = 0; i < 4; i++) begin
			sh   = {32'd0, value} >> desc[i].pos;
			mask = (16'd1 << desc[i].nbits) - 16'd1;
			fld  = sh[14:0] & mask[14:0];
			v    = widen_to_8(fld, desc[i].nbits);
			if (desc[i].nbits != 4'd0) begin
				unique case (desc[i].kind)
					CH_RED:   r = v;
					CH_GREEN: g = v;
					CH_BLUE:  b = v;
					CH_ALPHA: a = v;
					CH_GREY: begin
						r = v;
						g = v;
						b = v;
					end
					default: ;
				endcase
			end
		end
		unpacked = {r, g, b, a};
	end

	always_comb begin
		logic [63:0] acc;
		logic [14:0] f;
		acc = 64'd0;
		for (int i = 0; i < 4; i++) begin
			unique case (desc[i].kind)
				CH_RED:   f = narrow_from_8(r_in, desc[i].nbits);
				CH_GREEN: f = narrow_from_8(g_in, desc[i].nbits);
				CH_BLUE:  f = narrow_from_8(b_in, desc[i].nbits);
				CH_ALPHA: f = narrow_from_8(a_in, desc[i].nbits);
				CH_GREY:  f = narrow_from_8(grey, desc[i].nbits);
				default:  f = 15'd0;
			endcase
			if (desc[i].nbits != 4'd0) begin
				acc = acc | ({49'd0, f} << desc[i].pos);
			end
		end
		packed_px = acc[31:0];
	end

	assign result = (op == OP_PACK) ? packed_px : unpacked;

endmodule

@@ rtl/core/pixel_channel_format_convert.sv @@
// ----------------------------------------------------------------------------
// pixel_channel_format_convert
// Pipeline: an accepted item passes the input register and then the result register before out_valid.
// Throughput: one item per cycle while out_ready does not stall the output; the conversion is one pass of logic.
// Reset: arst_n clears both stage valids and loads descriptor 0x00081828.
// Converts pixels between a descriptor-defined packed format and RGBA32.
// ----------------------------------------------------------------------------
module pixel_channel_format_convert import pcfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write_en,
	input  logic [31:0] cfg_write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [31:0] value_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] value_out
);

	desc_t       desc_q;
	logic        valid_s1;
	logic        op_s1;
	logic [31:0] value_s1;
	logic        valid_s2;
	logic [31:0] result_s2;
	logic [31:0] result;
	logic        adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desc_q <= decode_desc(DESCRIPTOR_RESET);
		end else if (cfg_write_en) begin
			desc_q <= decode_desc(cfg_write_data);
		end
	end

	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1    <= opcode;
			value_s1 <= value_in;
		end
	end

	pcfc_convert u_convert (
		.op     (op_s1),
		.value  (value_s1),
		.desc   (desc_q),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign value_out = result_s2;

endmodule
